>>> hw/rtl/frd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_pkg
// Shared constants, state encoding and the controller/datapath interface types
// for the rounded decimal quotient core.
// ----------------------------------------------------------------------------
package frd_pkg;

   localparam int DIGITS      = 32;
   localparam int NUM_W       = 32;
   localparam int DEN_W       = 32;
   localparam int VALUE_W     = 33;
   localparam int DIGIT_W     = 4;
   localparam int PROD_W      = DEN_W + DIGIT_W;
   localparam int CNT_W       = $clog2(DIGITS + 1);
   localparam int IDX_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int STEP_W      = $clog2(NUM_W);
   localparam int REQ_TDATA_W = NUM_W + DEN_W;
   localparam int RSP_TDATA_W = ((VALUE_W + 7) / 8) * 8;

   localparam logic KIND_INT   = 1'b0;
   localparam logic KIND_DIGIT = 1'b1;

   localparam logic [DIGIT_W-1:0] DIGIT_ZERO = DIGIT_W'(0);
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INT,
      ST_MUL,
      ST_DIG,
      ST_FIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic int_step;
      logic mul;
      logic dig;
      logic fin;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic int_done;
      logic frac_done;
      logic emit_last;
   } status_type;

endpackage

>>> hw/rtl/frd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_dp
// Datapath: restoring integer divider, decimal digits from stored multiples of
// the denominator (multiply step, digit step), digit buffer and result register.
// ----------------------------------------------------------------------------
module frd_dp
   import frd_pkg::*;
(
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic [NUM_W-1:0]   numerator,
   input  logic [DEN_W-1:0]   denominator,
   output status_type         status,
   output logic               out_kind,
   output logic [VALUE_W-1:0] out_value,
   output logic               out_last
);

   logic [VALUE_W-1:0] quo_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [PROD_W-1:0]  mult_ff [1:9];
   logic [PROD_W-1:0]  mult_in [1:9];
   logic [PROD_W-1:0]  t_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   nz_ff;
   logic [CNT_W-1:0]   n9_ff;
   logic [CNT_W-1:0]   fcnt_ff;
   logic [CNT_W-1:0]   opos_ff;
   logic               round_ff;
   logic [DIGIT_W-1:0] digit_ff [DIGITS];
   logic               out_kind_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_last_ff;

   logic [PROD_W-1:0]  den_ext;
   logic [DEN_W:0]     int_pr;
   logic [DEN_W+1:0]   int_diff;
   logic               int_ge;
   logic [PROD_W:0]    dig_diff [1:9];
   logic [DIGIT_W-1:0] dig_sel;
   logic [DEN_W-1:0]   rem_sel;
   logic               round_now;
   logic [CNT_W-1:0]   opos_m1;
   logic [DIGIT_W-1:0] digit_rd;
   logic [DIGIT_W-1:0] digit_out;

   always_comb begin
      den_ext    = {{DIGIT_W{1'b0}}, denominator};
      mult_in[1] = den_ext;
      mult_in[2] = den_ext << 1;
      mult_in[3] = (den_ext << 1) + den_ext;
      mult_in[4] = den_ext << 2;
      mult_in[5] = (den_ext << 2) + den_ext;
      mult_in[6] = ((den_ext << 1) + den_ext) << 1;
      mult_in[7] = (den_ext << 3) - den_ext;
      mult_in[8] = den_ext << 3;
      mult_in[9] = (den_ext << 3) + den_ext;
   end

   always_comb begin
      int_pr   = {rem_ff, quo_ff[NUM_W-1]};
      int_diff = {1'b0, int_pr} - {2'b00, den_ff};
      int_ge   = !int_diff[DEN_W+1];
   end

   always_comb begin
      dig_sel = DIGIT_ZERO;
      rem_sel = t_ff[DEN_W-1:0];
      for (int k = 1; k <= 9; k++) begin
         dig_diff[k] = {1'b0, t_ff} - {1'b0, mult_ff[k]};
         if (!dig_diff[k][PROD_W]) begin
            dig_sel = DIGIT_W'(k);
            rem_sel = dig_diff[k][DEN_W-1:0];
         end
      end
   end

   assign round_now = (idx_ff == CNT_W'(DIGITS)) && (rem_ff != '0) &&
                      ({rem_ff, 1'b0} >= {1'b0, den_ff});

   always_comb begin
      opos_m1   = opos_ff - CNT_W'(1);
      digit_rd  = digit_ff[opos_m1[IDX_W-1:0]];
      digit_out = digit_rd + DIGIT_W'(round_ff && (opos_ff == fcnt_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quo_ff   <= {1'b0, numerator};
         rem_ff   <= '0;
         den_ff   <= denominator;
         mult_ff  <= mult_in;
         step_ff  <= '0;
         idx_ff   <= '0;
         nz_ff    <= '0;
         n9_ff    <= '0;
         round_ff <= 1'b0;
      end else if (cmd.int_step) begin
         rem_ff  <= int_ge ? int_diff[DEN_W-1:0] : int_pr[DEN_W-1:0];
         quo_ff  <= {1'b0, quo_ff[NUM_W-2:0], int_ge};
         step_ff <= step_ff + STEP_W'(1);
      end else if (cmd.mul) begin
         t_ff <= ({{DIGIT_W{1'b0}}, rem_ff} << 3) + ({{DIGIT_W{1'b0}}, rem_ff} << 1);
      end else if (cmd.dig) begin
         digit_ff[idx_ff[IDX_W-1:0]] <= dig_sel;
         rem_ff <= rem_sel;
         idx_ff <= idx_ff + CNT_W'(1);
         if (dig_sel != DIGIT_ZERO) begin
            nz_ff <= idx_ff + CNT_W'(1);
         end
         if (dig_sel != DIGIT_NINE) begin
            n9_ff <= idx_ff + CNT_W'(1);
         end
      end else if (cmd.fin) begin
         opos_ff  <= '0;
         round_ff <= round_now;
         if (round_now) begin
            if (n9_ff == '0) begin
               quo_ff  <= quo_ff + VALUE_W'(1);
               fcnt_ff <= '0;
            end else begin
               fcnt_ff <= n9_ff;
            end
         end else begin
            fcnt_ff <= nz_ff;
         end
      end else if (cmd.emit) begin
         opos_ff     <= opos_ff + CNT_W'(1);
         out_last_ff <= (opos_ff == fcnt_ff);
         if (opos_ff == '0) begin
            out_kind_ff  <= KIND_INT;
            out_value_ff <= quo_ff;
         end else begin
            out_kind_ff  <= KIND_DIGIT;
            out_value_ff <= {{(VALUE_W-DIGIT_W){1'b0}}, digit_out};
         end
      end
   end

   always_comb begin
      status.den_zero  = (den_ff == '0);
      status.int_done  = (step_ff == STEP_W'(NUM_W - 1));
      status.frac_done = (rem_ff == '0) || (idx_ff == CNT_W'(DIGITS));
      status.emit_last = (opos_ff == fcnt_ff);
   end

   assign out_kind  = out_kind_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule

>>> hw/rtl/frd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_ctrl
// Controller: sequences division, digit generation, rounding and result
// delivery, and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module frd_ctrl
   import frd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      valid_ff;
   logic      valid_in;
   logic      can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      can_load = !valid_ff || rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_INT;
            end
         end
         ST_INT: begin
            cmd.int_step = 1'b1;
            if (status.int_done) begin
               state_in = status.den_zero ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.frac_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_DIG;
            end
         end
         ST_DIG: begin
            cmd.dig  = 1'b1;
            state_in = ST_MUL;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_load) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule

>>> hw/rtl/fraction_to_rounded_decimal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_to_rounded_decimal_core
// Decimal quotient of two unsigned 32-bit values: integer part, then up to
// DIGITS fractional digits, rounded half up, with trailing zeros dropped.
// The restoring divider runs first; each fractional digit then takes a
// multiply step and a digit step. Results leave at one per cycle while
// rsp_tready is high; a new request is taken only after the last is issued.
// Synchronous active-high reset idles the controller and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module fraction_to_rounded_decimal_core
   import frd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // numerator, denominator
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // value, zero padding
   output logic                   rsp_tuser,  // kind
   output logic                   rsp_tlast
);

   cmd_type            cmd;
   status_type         status;
   logic [VALUE_W-1:0] out_value;

   frd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   frd_dp u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .numerator   (req_tdata[NUM_W-1:0]),
      .denominator (req_tdata[NUM_W+DEN_W-1:NUM_W]),
      .status      (status),
      .out_kind    (rsp_tuser),
      .out_value   (out_value),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-VALUE_W){1'b0}}, out_value};

endmodule

>>> hw/rtl/frd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_checker
// Port-level checks on the rounded decimal quotient core, bound to its top.
// ----------------------------------------------------------------------------
module frd_checker
   import frd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("Stalled result item changed.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DIGIT) |->
         (rsp_tdata[RSP_TDATA_W-1:DIGIT_W] == '0) && (rsp_tdata[DIGIT_W-1:0] <= DIGIT_NINE))
      else $error("Fractional digit out of range.");

   a_last_digit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DIGIT) && rsp_tlast |->
         (rsp_tdata[DIGIT_W-1:0] != DIGIT_ZERO))
      else $error("Trailing zero digit delivered.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Input ready right after an accepted item.");

endmodule

bind fraction_to_rounded_decimal_core frd_checker u_frd_checker (.*);
